/* rtl/core/priority_voice_allocator_macros.svh */
// Assertion macros for the priority voice allocator.
// Used by the RTL files that carry concurrent checks; needs clk_i and rst_ni in scope.
`ifndef PRIORITY_VOICE_ALLOCATOR_MACROS_SVH
`define PRIORITY_VOICE_ALLOCATOR_MACROS_SVH

// Clocked check that is switched off while reset is asserted.
`define PVA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked check that also holds while reset is asserted.
`define PVA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* rtl/core/pva_pkg.sv */
// Shared types and constants of the priority voice allocator.
// No dependencies; imported by pva_engine and priority_voice_allocator.
package pva_pkg;

  localparam int unsigned VOICES_DEF  = 8;
  localparam int unsigned FUNC_W      = 2;
  localparam int unsigned PRIO_W      = 8;
  localparam int unsigned ID_W        = 32;
  localparam int unsigned MASK_W      = 8;
  localparam int unsigned VOICE_OUT_W = 3;
  localparam int unsigned IN_DATA_W   = 48;
  localparam int unsigned OUT_DATA_W  = 40;

  localparam logic [FUNC_W-1:0] FUNC_PLAY = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_STOP = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]        handle;
    logic [VOICE_OUT_W-1:0] voice;
    logic                   ok;
  } pva_result_t;

endpackage

/* rtl/core/pva_engine.sv */
// Single-pass next-state and result logic of the voice allocator.
// Depends on pva_pkg; purely combinational, used by priority_voice_allocator.
module pva_engine #(
  parameter int unsigned VOICES = pva_pkg::VOICES_DEF,
  localparam int unsigned VW = (VOICES > 1) ? $clog2(VOICES) : 1
) (
  input  logic [pva_pkg::FUNC_W-1:0] func_i,
  input  logic [pva_pkg::PRIO_W-1:0] req_priority_i,
  input  logic [pva_pkg::ID_W-1:0]   stop_id_i,
  input  logic [pva_pkg::MASK_W-1:0] playing_mask_i,
  input  logic [pva_pkg::PRIO_W-1:0] prio_i [VOICES],
  input  logic [pva_pkg::ID_W-1:0]   id_i [VOICES],
  input  logic [VW-1:0]              voice_i [VOICES],
  input  logic [pva_pkg::ID_W-1:0]   cnt_i,
  output logic [pva_pkg::PRIO_W-1:0] prio_o [VOICES],
  output logic [pva_pkg::ID_W-1:0]   id_o [VOICES],
  output logic [VW-1:0]              voice_o [VOICES],
  output logic [pva_pkg::ID_W-1:0]   cnt_o,
  output pva_pkg::pva_result_t       result_o
);
  import pva_pkg::*;

  // Play: insertion point and the table shifted down by one rank.
  logic              play_hit;
  logic [VW-1:0]     play_pos;
  logic [ID_W-1:0]   new_id;
  logic [PRIO_W-1:0] sh_prio [VOICES];
  logic [ID_W-1:0]   sh_id [VOICES];
  logic [VW-1:0]     sh_voice [VOICES];
  logic [VW+2:0]     stolen_ext;

  // Stop: id lookup.
  logic              stop_hit;
  logic [VW-1:0]     stop_voice;
  logic [VW+2:0]     stop_ext;

  // Tick: cleared entries, their sorted destinations.
  logic [MASK_W-1:0] mask_sh [VOICES];
  logic [PRIO_W-1:0] clr_prio [VOICES];
  logic [ID_W-1:0]   clr_id [VOICES];
  logic [VW-1:0]     dest [VOICES];
  logic [PRIO_W-1:0] srt_prio [VOICES];
  logic [ID_W-1:0]   srt_id [VOICES];
  logic [VW-1:0]     srt_voice [VOICES];

  always_comb begin
    play_hit = 1'b0;
    play_pos = '0;
    for (int i = VOICES - 1; i >= 0; i--) begin
      if (prio_i[i] <= req_priority_i) begin
        play_hit = 1'b1;
        play_pos = VW'(i);
      end
    end
    sh_prio[0]  = prio_i[0];
    sh_id[0]    = id_i[0];
    sh_voice[0] = voice_i[0];
    for (int i = 1; i < VOICES; i++) begin
      sh_prio[i]  = prio_i[i-1];
      sh_id[i]    = id_i[i-1];
      sh_voice[i] = voice_i[i-1];
    end
    // The counter wraps past zero straight to one.
    new_id     = (cnt_i == {ID_W{1'b1}}) ? ID_W'(1) : cnt_i + ID_W'(1);
    stolen_ext = {3'b000, voice_i[VOICES-1]};
  end

  always_comb begin
    stop_hit   = 1'b0;
    stop_voice = '0;
    for (int i = VOICES - 1; i >= 0; i--) begin
      if (id_i[i] == stop_id_i) begin
        stop_hit   = 1'b1;
        stop_voice = voice_i[i];
      end
    end
    stop_ext = {3'b000, stop_voice};
  end

  // Voices numbered at or above the mask width shift the mask out entirely and count as finished.
  always_comb begin
    for (int i = 0; i < VOICES; i++) begin
      mask_sh[i]  = playing_mask_i >> voice_i[i];
      clr_prio[i] = mask_sh[i][0] ? prio_i[i] : '0;
      clr_id[i]   = mask_sh[i][0] ? id_i[i] : '0;
    end
  end

  // Stable sort as a rank count: an entry goes behind every higher one and every
  // equal one that stood before it.
  always_comb begin
    for (int i = 0; i < VOICES; i++) begin
      dest[i] = '0;
      for (int j = 0; j < VOICES; j++) begin
        if ((clr_prio[j] > clr_prio[i]) || ((clr_prio[j] == clr_prio[i]) && (j < i))) begin
          dest[i] = dest[i] + VW'(1);
        end
      end
    end
    for (int r = 0; r < VOICES; r++) begin
      srt_prio[r]  = clr_prio[r];
      srt_id[r]    = clr_id[r];
      srt_voice[r] = voice_i[r];
      for (int k = 0; k < VOICES; k++) begin
        if (dest[k] == VW'(r)) begin
          srt_prio[r]  = clr_prio[k];
          srt_id[r]    = clr_id[k];
          srt_voice[r] = voice_i[k];
        end
      end
    end
  end

  always_comb begin
    prio_o   = prio_i;
    id_o     = id_i;
    voice_o  = voice_i;
    cnt_o    = cnt_i;
    result_o = '0;
    case (func_i)
      FUNC_PLAY: begin
        if (play_hit) begin
          for (int i = 0; i < VOICES; i++) begin
            if (VW'(i) == play_pos) begin
              prio_o[i]  = req_priority_i;
              id_o[i]    = new_id;
              voice_o[i] = voice_i[VOICES-1];
            end else if (VW'(i) > play_pos) begin
              prio_o[i]  = sh_prio[i];
              id_o[i]    = sh_id[i];
              voice_o[i] = sh_voice[i];
            end
          end
          cnt_o           = new_id;
          result_o.ok     = 1'b1;
          result_o.voice  = stolen_ext[VOICE_OUT_W-1:0];
          result_o.handle = new_id;
        end
      end
      FUNC_STOP: begin
        result_o.ok    = stop_hit;
        result_o.voice = stop_ext[VOICE_OUT_W-1:0];
      end
      FUNC_TICK: begin
        prio_o      = srt_prio;
        id_o        = srt_id;
        voice_o     = srt_voice;
        result_o.ok = 1'b1;
      end
      default: begin
        result_o = '0;
      end
    endcase
  end

endmodule

/* rtl/core/priority_voice_allocator.sv */
// Flow: a request accepted into the request register is processed into the result register
// whenever that register is free or drains, and is then shown at the master port.
// Throughput: one request per cycle while results are taken; the rank table is read and
// rewritten between the request and the result register, so that update sets the rate.
// Reset (rst_ni low, asynchronous): all priorities and ids clear, rank i holds voice i, the
// id counter is zero, and both the request and the result register are empty.
//
// Top level of the priority voice allocator; depends on pva_pkg, pva_engine and the
// assertion macros in priority_voice_allocator_macros.svh.
`include "priority_voice_allocator_macros.svh"

module priority_voice_allocator #(
  parameter int unsigned VOICES = pva_pkg::VOICES_DEF,
  localparam int unsigned VW = (VOICES > 1) ? $clog2(VOICES) : 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Request channel.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata, lowest bit first: req_priority[7:0], stop_id[39:8], playing_mask[47:40].
  input  logic [pva_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: func[1:0] (play, stop, tick).
  input  logic [pva_pkg::FUNC_W-1:0]     s_axis_tuser,
  // Result channel.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata, lowest bit first: ok[0], voice[3:1], handle[35:4], zero fill [39:36].
  output logic [pva_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import pva_pkg::*;

  // Request register. It is loaded whenever it is empty or its request moves on
  // in the same cycle, so a new request can enter on every edge.
  logic              req_valid_q;
  logic [FUNC_W-1:0] req_func_q;
  logic [PRIO_W-1:0] req_prio_q;
  logic [ID_W-1:0]   req_sid_q;
  logic [MASK_W-1:0] req_mask_q;

  // Rank table, highest priority first, and the effect id counter.
  logic [PRIO_W-1:0] prio_q [VOICES];
  logic [ID_W-1:0]   id_q [VOICES];
  logic [VW-1:0]     voice_q [VOICES];
  logic [ID_W-1:0]   cnt_q;

  logic [PRIO_W-1:0] prio_d [VOICES];
  logic [ID_W-1:0]   id_d [VOICES];
  logic [VW-1:0]     voice_d [VOICES];
  logic [ID_W-1:0]   cnt_d;

  // Result register.
  logic              res_valid_q;
  pva_result_t       res_q;
  pva_result_t       res_d;

  logic              proc;
  logic              req_load;
  logic              tbl_sorted;

  // A request is processed when the result register is free or drains this cycle.
  // The table and counter commit on the same edge, so the next request sees them.
  assign proc          = req_valid_q && (!res_valid_q || m_axis_tready);
  assign s_axis_tready = !req_valid_q || proc;
  assign req_load      = s_axis_tvalid && s_axis_tready;

  pva_engine #(
    .VOICES(VOICES)
  ) u_engine (
    .func_i        (req_func_q),
    .req_priority_i(req_prio_q),
    .stop_id_i     (req_sid_q),
    .playing_mask_i(req_mask_q),
    .prio_i        (prio_q),
    .id_i          (id_q),
    .voice_i       (voice_q),
    .cnt_i         (cnt_q),
    .prio_o        (prio_d),
    .id_o          (id_d),
    .voice_o       (voice_d),
    .cnt_o         (cnt_d),
    .result_o      (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
      cnt_q       <= '0;
      for (int i = 0; i < VOICES; i++) begin
        prio_q[i]  <= '0;
        id_q[i]    <= '0;
        voice_q[i] <= VW'(i);
      end
    end else begin
      if (s_axis_tready) begin
        req_valid_q <= s_axis_tvalid;
      end
      if (proc) begin
        res_valid_q <= 1'b1;
        prio_q      <= prio_d;
        id_q        <= id_d;
        voice_q     <= voice_d;
        cnt_q       <= cnt_d;
      end else if (m_axis_tready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset; their valid flags guard them.
  always_ff @(posedge clk_i) begin
    if (req_load) begin
      req_func_q <= s_axis_tuser;
      req_prio_q <= s_axis_tdata[PRIO_W-1:0];
      req_sid_q  <= s_axis_tdata[PRIO_W +: ID_W];
      req_mask_q <= s_axis_tdata[PRIO_W+ID_W +: MASK_W];
    end
    if (proc) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = res_valid_q;
  assign m_axis_tdata  = {{(OUT_DATA_W - ID_W - VOICE_OUT_W - 1){1'b0}},
                          res_q.handle, res_q.voice, res_q.ok};

  // Descending order across the whole table, checked after every tick.
  always_comb begin
    tbl_sorted = 1'b1;
    for (int i = 1; i < VOICES; i++) begin
      if (prio_q[i] > prio_q[i-1]) begin
        tbl_sorted = 1'b0;
      end
    end
  end

  `PVA_ASSERT(a_reject_keeps_counter, proc && (req_func_q == FUNC_PLAY) && !res_d.ok |=> $stable(cnt_q), "rejected play moved the id counter")
  `PVA_ASSERT(a_counter_skips_zero, proc && (req_func_q == FUNC_PLAY) && res_d.ok |=> (cnt_q != '0), "id counter handed out zero")
  `PVA_ASSERT(a_handle_needs_ok, res_valid_q && (res_q.handle != '0) |-> res_q.ok, "handle given on a failed request")
  `PVA_ASSERT(a_tick_sorts, proc && (req_func_q == FUNC_TICK) |=> tbl_sorted, "rank table out of order after tick")
  `PVA_ASSERT_ALWAYS(a_full_pipe_stalls, req_valid_q && res_valid_q && !m_axis_tready |-> !s_axis_tready, "request taken while both registers are blocked")

endmodule

/* test/pva_result_checker.sv */
`timescale 1ns / 100ps
// Result checker for the priority voice allocator: watches both streams, keeps its own rank
// table and compares every result with the oldest prediction. Depends on pva_pkg.
module pva_result_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  // tdata, lowest bit first: req_priority, stop_id, playing_mask.
  input  logic [pva_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: func.
  input  logic [pva_pkg::FUNC_W-1:0]     s_axis_tuser,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata, lowest bit first: ok, voice, handle, zero fill.
  input  logic [pva_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output int unsigned                    mismatch_count_o,
  output int unsigned                    outstanding_o,
  output logic [pva_pkg::ID_W-1:0]       newest_handle_o
);

  localparam int NV = pva_pkg::VOICES_DEF;
  localparam int PW = pva_pkg::PRIO_W;
  localparam int IW = pva_pkg::ID_W;
  localparam int MW = pva_pkg::MASK_W;
  localparam int RW = $bits(pva_pkg::pva_result_t);

  // Rank table, highest priority first, and the id counter.
  logic [PW-1:0]                   slot_prio   [NV];
  logic [IW-1:0]                   slot_handle [NV];
  logic [pva_pkg::VOICE_OUT_W-1:0] slot_voice  [NV];
  logic [IW-1:0]                   handle_ctr;

  pva_pkg::pva_result_t awaited_q [$];
  pva_pkg::pva_result_t predicted;
  pva_pkg::pva_result_t observed;
  pva_pkg::pva_result_t wanted;
  int unsigned          errors;

  function automatic void clear_table();
    for (int k = 0; k < NV; k++) begin
      slot_prio[k]   = '0;
      slot_handle[k] = '0;
      slot_voice[k]  = pva_pkg::VOICE_OUT_W'(k);
    end
    handle_ctr = '0;
  endfunction

  // Play: the lowest voice is stolen and placed at the first rank not above the request.
  function automatic pva_pkg::pva_result_t start_voice(input logic [PW-1:0] prio);
    pva_pkg::pva_result_t            res;
    int                              slot;
    logic [pva_pkg::VOICE_OUT_W-1:0] victim;
    res  = '0;
    slot = -1;
    for (int k = NV - 1; k >= 0; k--) begin
      if (slot_prio[k] <= prio) slot = k;
    end
    if (slot >= 0) begin
      victim = slot_voice[NV-1];
      for (int k = NV - 1; k > slot; k--) begin
        slot_prio[k]   = slot_prio[k-1];
        slot_handle[k] = slot_handle[k-1];
        slot_voice[k]  = slot_voice[k-1];
      end
      handle_ctr = handle_ctr + 1'b1;
      if (handle_ctr == '0) handle_ctr = 1;
      slot_prio[slot]   = prio;
      slot_handle[slot] = handle_ctr;
      slot_voice[slot]  = victim;
      res.ok     = 1'b1;
      res.voice  = victim;
      res.handle = handle_ctr;
    end
    return res;
  endfunction

  // Stop only reports the voice; a free entry carries id zero and can match too.
  function automatic pva_pkg::pva_result_t find_voice(input logic [IW-1:0] id);
    pva_pkg::pva_result_t res;
    logic                 hit;
    res = '0;
    hit = 1'b0;
    for (int k = 0; k < NV; k++) begin
      if (!hit && slot_handle[k] == id) begin
        hit       = 1'b1;
        res.ok    = 1'b1;
        res.voice = slot_voice[k];
      end
    end
    return res;
  endfunction

  // Tick frees finished voices, then a bubble sort with a strict compare keeps ties in order.
  function automatic pva_pkg::pva_result_t retire_voices(input logic [MW-1:0] still_on);
    pva_pkg::pva_result_t            res;
    logic [PW-1:0]                   tmp_prio;
    logic [IW-1:0]                   tmp_handle;
    logic [pva_pkg::VOICE_OUT_W-1:0] tmp_voice;
    for (int k = 0; k < NV; k++) begin
      if (!still_on[slot_voice[k]]) begin
        slot_prio[k]   = '0;
        slot_handle[k] = '0;
      end
    end
    for (int pass = 0; pass < NV - 1; pass++) begin
      for (int k = 0; k < NV - 1; k++) begin
        if (slot_prio[k] < slot_prio[k+1]) begin
          tmp_prio         = slot_prio[k];
          tmp_handle       = slot_handle[k];
          tmp_voice        = slot_voice[k];
          slot_prio[k]     = slot_prio[k+1];
          slot_handle[k]   = slot_handle[k+1];
          slot_voice[k]    = slot_voice[k+1];
          slot_prio[k+1]   = tmp_prio;
          slot_handle[k+1] = tmp_handle;
          slot_voice[k+1]  = tmp_voice;
        end
      end
    end
    res    = '0;
    res.ok = 1'b1;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_table();
      awaited_q.delete();
      errors = 0;
      mismatch_count_o <= 0;
      outstanding_o    <= 0;
      newest_handle_o  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        case (s_axis_tuser)
          pva_pkg::FUNC_PLAY: predicted = start_voice(s_axis_tdata[PW-1:0]);
          pva_pkg::FUNC_STOP: predicted = find_voice(s_axis_tdata[PW +: IW]);
          pva_pkg::FUNC_TICK: predicted = retire_voices(s_axis_tdata[PW+IW +: MW]);
          default:            predicted = '0;
        endcase
        awaited_q.push_back(predicted);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        observed = m_axis_tdata[RW-1:0];
        if (awaited_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: result with no request pending: ok %0b voice %0d handle %0h",
                     $realtime, observed.ok, observed.voice, observed.handle);
        end else begin
          wanted = awaited_q.pop_front();
          if (observed.ok !== wanted.ok || observed.voice !== wanted.voice ||
              observed.handle !== wanted.handle) begin
            errors++;
            if (errors <= 10)
              $display("%0t: mismatch: expected ok %0b voice %0d handle %0h, got ok %0b voice %0d handle %0h",
                       $realtime, wanted.ok, wanted.voice, wanted.handle,
                       observed.ok, observed.voice, observed.handle);
          end
        end
      end
      mismatch_count_o <= errors;
      outstanding_o    <= awaited_q.size();
      newest_handle_o  <= handle_ctr;
    end
  end

endmodule

/* test/priority_voice_allocator_tb.sv */
`timescale 1ns / 100ps
// Testbench top for the priority voice allocator: drives play, stop and tick requests with
// random gaps and back-pressure and gives the verdict. Depends on pva_pkg and pva_result_checker.
module priority_voice_allocator_tb;

  localparam logic [pva_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int unsigned RANDOM_REQUESTS = 850;
  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned DRAIN_CYCLES    = 8;

  logic                           clk_i         = 1'b0;
  logic                           rst_ni        = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [pva_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [pva_pkg::FUNC_W-1:0]     s_axis_tuser  = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [pva_pkg::OUT_DATA_W-1:0] m_axis_tdata;

  int unsigned                mismatches;
  int unsigned                outstanding;
  logic [pva_pkg::ID_W-1:0]   newest_handle;
  int unsigned                cycle_count = 0;
  // When set, neither side inserts idle cycles.
  logic                       steady = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  priority_voice_allocator u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  pva_result_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tuser     (s_axis_tuser),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .mismatch_count_o (mismatches),
    .outstanding_o    (outstanding),
    .newest_handle_o  (newest_handle)
  );

  function automatic int unsigned idle_cycles();
    return steady ? 0 : $urandom_range(0, 17);
  endfunction

  // Holds a request on the stream until the block takes it; valid stays high afterwards
  // so that back-to-back requests need no second assignment in the same step.
  task automatic issue_request(input logic [pva_pkg::FUNC_W-1:0] op,
                               input logic [pva_pkg::PRIO_W-1:0] prio,
                               input logic [pva_pkg::ID_W-1:0]   id,
                               input logic [pva_pkg::MASK_W-1:0] still_on);
    int unsigned gap;
    gap = idle_cycles();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {still_on, id, prio};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // The checker's counters are registered, so the first look is taken at the edge after valid drops.
  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  initial begin : result_sink
    int unsigned stall;
    @(posedge clk_i);
    forever begin
      stall = idle_cycles();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned                counted;
    int unsigned                pick;
    logic                       drained;
    logic [pva_pkg::FUNC_W-1:0] op;
    logic [pva_pkg::PRIO_W-1:0] prio;
    logic [pva_pkg::ID_W-1:0]   id;
    logic [pva_pkg::MASK_W-1:0] still_on;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty table: id zero finds the free top rank, an unknown id misses.
    issue_request(pva_pkg::FUNC_STOP, 8'h00, 32'h0000_0000, 8'h00);
    issue_request(pva_pkg::FUNC_STOP, 8'hFF, 32'hFFFF_FFFF, 8'hFF);
    issue_request(FUNC_UNUSED, 8'hFF, 32'hFFFF_FFFF, 8'hFF);
    issue_request(pva_pkg::FUNC_TICK, 8'h00, 32'h0000_0000, 8'h00);
    // Lowest priority still wins over free ranks; it gets handle 1.
    issue_request(pva_pkg::FUNC_PLAY, 8'h00, 32'h0000_0000, 8'h00);
    // Fill every rank at top priority (handles 2 to 9), stealing the bottom voice each time.
    repeat (8) issue_request(pva_pkg::FUNC_PLAY, 8'hFF, 32'h0000_0000, 8'h00);
    // Every rank is above these requests, so both are rejected.
    issue_request(pva_pkg::FUNC_PLAY, 8'hFE, 32'hFFFF_FFFF, 8'hFF);
    issue_request(pva_pkg::FUNC_PLAY, 8'h00, 32'h0000_0000, 8'h00);
    // An equal priority is not above the request: accepted with handle 10.
    issue_request(pva_pkg::FUNC_PLAY, 8'hFF, 32'h0000_0000, 8'h00);
    issue_request(pva_pkg::FUNC_STOP, 8'h00, 32'd10, 8'h00);
    issue_request(pva_pkg::FUNC_STOP, 8'h00, 32'd1, 8'h00);
    // No free entry remains, so id zero misses.
    issue_request(pva_pkg::FUNC_STOP, 8'h00, 32'h0000_0000, 8'h00);
    issue_request(pva_pkg::FUNC_TICK, 8'h00, 32'h0000_0000, 8'hFF);
    issue_request(pva_pkg::FUNC_TICK, 8'h00, 32'h0000_0000, 8'h55);
    issue_request(pva_pkg::FUNC_STOP, 8'h00, 32'h0000_0000, 8'h00);
    issue_request(pva_pkg::FUNC_TICK, 8'h00, 32'h0000_0000, 8'h00);
    // Mixed priorities, then a partial tick so the re-sort has work to do.
    issue_request(pva_pkg::FUNC_PLAY, 8'd10, 32'h0000_0000, 8'h00);
    issue_request(pva_pkg::FUNC_PLAY, 8'd200, 32'h0000_0000, 8'h00);
    issue_request(pva_pkg::FUNC_PLAY, 8'd100, 32'h0000_0000, 8'h00);
    issue_request(pva_pkg::FUNC_TICK, 8'h00, 32'h0000_0000, 8'hF0);

    // Let the block run dry once before the random part.
    wait_for_drain();

    counted = 0;
    drained = 1'b0;
    while (counted < RANDOM_REQUESTS) begin
      if (counted % 64 == 0) steady <= ($urandom_range(0, 3) == 0);
      if (counted == RANDOM_REQUESTS / 2 && !drained) begin
        drained = 1'b1;
        wait_for_drain();
      end

      prio     = $urandom;
      id       = $urandom;
      still_on = $urandom;
      pick     = $urandom_range(0, 99);
      if (pick < 45) begin
        op = pva_pkg::FUNC_PLAY;
        // Mostly a narrow band, so the table fills with near ties and rejections happen.
        case ($urandom_range(0, 3))
          0:       prio = $urandom_range(0, 255);
          3:       prio = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          default: prio = $urandom_range(120, 135);
        endcase
      end else if (pick < 70) begin
        op = pva_pkg::FUNC_STOP;
        // Mostly recent handles, which are likely still in the table.
        case ($urandom_range(0, 7))
          6:       id = '0;
          7:       id = $urandom;
          default: id = newest_handle - $urandom_range(0, 9);
        endcase
      end else if (pick < 93) begin
        op = pva_pkg::FUNC_TICK;
        case ($urandom_range(0, 4))
          0:       still_on = 8'hFF;
          1:       still_on = $urandom | $urandom;
          2:       still_on = $urandom;
          3:       still_on = $urandom & $urandom;
          default: still_on = $urandom_range(0, 1) ? ($urandom | $urandom | $urandom) : 8'h00;
        endcase
      end else begin
        op = FUNC_UNUSED;
      end

      issue_request(op, prio, id, still_on);
      if (op != FUNC_UNUSED) counted++;
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
